>>> rtl/rlenc_pkg.sv
// shared types and constants for the run length encoder
package rlenc_pkg;

  // material code and run counter widths
  localparam int unsigned MAT_W   = 8;
  localparam int unsigned COUNT_W = 16;

  // result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [MAT_W-1:0] in_material;
    logic             block_last;
  } in_item_t;

  typedef struct packed {
    logic [MAT_W-1:0]   out_material;
    logic [COUNT_W-1:0] run_length;
    logic               run_last;
  } out_item_t;

  // runs produced by the front for one accepted item, in delivery order
  typedef struct packed {
    logic [1:0] num;
    out_item_t  item0;
    out_item_t  item1;
  } front_push_t;

endpackage

>>> rtl/run_length_encoder_type_count.sv
// top level of the run length encoder for material code streams
//
// usage: one material code per input transfer on in_valid/in_ready, with
//   block_last set on the final code of a block. each finished run leaves
//   as one output transfer on out_valid/out_ready: the code, its length
//   (1 .. 2^16-1) and run_last, which marks the final run of a block.
// path: a run closed by an input transfer is written into the queue,
//   then loaded into the output register, which drives out_valid.
// throughput: one input transfer per cycle while the queue has room; the
//   run compare and increment in the front is the only per-item step. a
//   code that both ends a run and ends the block yields two runs, which
//   leave as two output transfers; the four-entry queue absorbs that.
// stall: the front takes codes while at least two queue slots are free;
//   a stalled receiver fills the queue and in_ready then drops.
// reset: synchronous, active low; no run is open, queue and output are
//   empty afterward.
module run_length_encoder_type_count (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rlenc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlenc_pkg::out_item_t out_data
);

  // front to queue
  rlenc_pkg::front_push_t push;
  logic                   q_room;
  // queue to back
  logic                   q_valid;
  logic                   q_pop;
  rlenc_pkg::out_item_t   q_item;

  // run tracking and classification of each code
  rlenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_room   (q_room),
    .push     (push)
  );

  // decouples run production from output stalls
  rlenc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_room  (q_room),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // registered output toward the receiver
  rlenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/rlenc_front.sv
// run tracker: accepts material codes and emits finished runs into the queue
module rlenc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rlenc_pkg::in_item_t   in_data,
  input  logic                  q_room,
  output rlenc_pkg::front_push_t push
);

  logic                          run_open_r, run_open_nxt;
  logic [rlenc_pkg::MAT_W-1:0]   run_value_r, run_value_nxt;
  logic [rlenc_pkg::COUNT_W-1:0] run_count_r, run_count_nxt;

  logic                          accept;
  logic                          flush_old;
  logic                          extend;
  logic [rlenc_pkg::MAT_W-1:0]   cur_value;
  logic [rlenc_pkg::COUNT_W-1:0] cur_count;
  rlenc_pkg::out_item_t          old_run;
  rlenc_pkg::out_item_t          end_run;

  assign in_ready = q_room;
  assign accept   = in_valid & in_ready;

  always_comb begin
    // a saturated run closes even when the code repeats
    flush_old = run_open_r &
                ((in_data.in_material != run_value_r) || (run_count_r == '1));
    extend    = run_open_r & ~flush_old;
    cur_value = in_data.in_material;
    cur_count = extend ? (run_count_r + rlenc_pkg::COUNT_W'(1)) : rlenc_pkg::COUNT_W'(1);

    old_run.out_material = run_value_r;
    old_run.run_length   = run_count_r;
    old_run.run_last     = 1'b0;
    end_run.out_material = cur_value;
    end_run.run_length   = cur_count;
    end_run.run_last     = 1'b1;

    push.num   = 2'd0;
    push.item0 = old_run;
    push.item1 = end_run;
    if (accept) begin
      if (flush_old && in_data.block_last) begin
        push.num = 2'd2;
      end else if (flush_old) begin
        push.num = 2'd1;
      end else if (in_data.block_last) begin
        push.num   = 2'd1;
        push.item0 = end_run;
      end
    end

    run_open_nxt  = run_open_r;
    run_value_nxt = run_value_r;
    run_count_nxt = run_count_r;
    if (accept) begin
      if (in_data.block_last) begin
        run_open_nxt  = 1'b0;
        run_value_nxt = '0;
        run_count_nxt = '0;
      end else begin
        run_open_nxt  = 1'b1;
        run_value_nxt = cur_value;
        run_count_nxt = cur_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_value_r <= '0;
      run_count_r <= '0;
    end else begin
      run_open_r  <= run_open_nxt;
      run_value_r <= run_value_nxt;
      run_count_r <= run_count_nxt;
    end
  end

endmodule

>>> rtl/rlenc_queue.sv
// small result queue: up to two writes and one read per cycle
module rlenc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rlenc_pkg::front_push_t push,
  output logic                   q_room,
  output logic                   q_valid,
  output rlenc_pkg::out_item_t   q_item,
  input  logic                   q_pop
);

  rlenc_pkg::out_item_t           entry_r [rlenc_pkg::QDEPTH];
  logic [rlenc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rlenc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rlenc_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic [rlenc_pkg::QPTR_W-1:0]   wr_ptr_p1;
  logic                           do_pop;

  assign q_valid   = (count_r != '0);
  assign q_item    = entry_r[rd_ptr_r];
  // front may push two runs, so keep two slots free
  assign q_room    = (count_r <= rlenc_pkg::QCNT_W'(rlenc_pkg::QDEPTH - 2));
  assign do_pop    = q_pop & q_valid;
  assign wr_ptr_p1 = wr_ptr_r + rlenc_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + rlenc_pkg::QPTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + rlenc_pkg::QPTR_W'(do_pop);
    count_nxt  = count_r + rlenc_pkg::QCNT_W'(push.num) - rlenc_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[wr_ptr_r] <= push.item0;
    end
    if (push.num == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/rlenc_back.sv
// output stage: pulls runs from the queue and holds them for the receiver
module rlenc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rlenc_pkg::out_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlenc_pkg::out_item_t out_data
);

  logic                 valid_r, valid_nxt;
  rlenc_pkg::out_item_t data_r, data_nxt;
  logic                 slot_free;

  assign slot_free = ~valid_r | out_ready;
  assign q_pop     = q_valid & slot_free;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (slot_free) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        data_nxt = q_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
